>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, no reset qualifier
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion, off while the active-low reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> sv/msat_pkg.sv
// ----------------------------------------------------------------------------
// msat_pkg
// Types, codes and header helpers for the 802.15.4 source address table
// ----------------------------------------------------------------------------
package msat_pkg;

    // default sizes
    localparam int unsigned TABLE_ENTRIES_DEF   = 64;
    localparam int unsigned MAX_FRAME_BYTES_DEF = 127;

    // fixed widths (cover the whole parameter range)
    localparam int unsigned IDX_W = 8;
    localparam int unsigned CNT_W = 9;

    // frame control field positions
    localparam int unsigned FCF_PAN_COMP_BIT = 6;

    // command codes
    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // frame outcome codes
    typedef enum logic [1:0] {
        OUT_NONE    = 2'd0,
        OUT_ADDED   = 2'd1,
        OUT_MATCHED = 2'd2,
        OUT_FULL    = 2'd3
    } t_outcome;

    // addressing modes
    typedef enum logic [1:0] {
        AMODE_NONE  = 2'd0,
        AMODE_RSVD  = 2'd1,
        AMODE_SHORT = 2'd2,
        AMODE_LONG  = 2'd3
    } t_amode;

    // query word that travels down the cell chain
    typedef struct packed {
        logic                vld;
        logic                is_read;
        logic                found;
        logic [IDX_W-1:0]    idx;
        logic [63:0]         addr;
        logic                is_long;
        logic signed [7:0]   new_rssi;
        logic signed [7:0]   rssi;
        logic [4:0]          ch;
    } t_token;

    // new entry write, broadcast to all cells
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [63:0]         addr;
        logic                is_long;
        logic signed [7:0]   rssi;
        logic [4:0]          ch;
    } t_wr;

    // byte offset of the source address within the frame
    function automatic logic [4:0] src_offset(input logic [15:0] fcf);
        logic [4:0] off;
        begin
            off = 5'd3;
            unique case (t_amode'(fcf[11:10]))
                AMODE_NONE:  off = off;
                AMODE_RSVD:  off = off + 5'd2;
                AMODE_SHORT: off = off + 5'd4;
                AMODE_LONG:  off = off + 5'd10;
                default:     off = off;
            endcase
            if (!fcf[FCF_PAN_COMP_BIT]) off = off + 5'd2;
            return off;
        end
    endfunction

    // source address length in bytes
    function automatic logic [3:0] src_len(input logic [15:0] fcf);
        logic [3:0] len;
        begin
            unique case (t_amode'(fcf[15:14]))
                AMODE_SHORT: len = 4'd2;
                AMODE_LONG:  len = 4'd8;
                default:     len = 4'd0;
            endcase
            return len;
        end
    endfunction

endpackage

>>> sv/mac_source_address_table.sv
// ----------------------------------------------------------------------------
// mac_source_address_table
// 802.15.4 source address collector with a deduplicating device table
// ----------------------------------------------------------------------------
// Results: a final byte without a usable source address gives its result in the cycle after
// it is taken; other frame bytes, clears and ignored commands give none.
// A final byte with a source address, or a read, sends a query down the row of
// TABLE_ENTRIES cells and its result is registered after the last cell; busy drops with
// the strobe, so no new word is taken until the result is out; no stalls.
// Reset (synchronous, active low) empties the table and restarts the frame parser.
module mac_source_address_table import msat_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_last_byte,
    input  logic signed [7:0] i_rssi,
    input  logic [4:0]        i_channel,
    input  logic [5:0]        i_read_index,
    output logic              o_strobe,
    output logic              o_result_kind,
    output logic [1:0]        o_outcome,
    output logic              o_entry_valid,
    output logic [63:0]       o_entry_addr,
    output logic              o_entry_addr_long,
    output logic signed [7:0] o_entry_rssi,
    output logic [4:0]        o_entry_channel,
    output logic [6:0]        o_device_count
);

    t_token           w_chain [TABLE_ENTRIES+1];
    logic [CNT_W-1:0] w_count;
    t_wr              w_wr;

    // parser and result formatting
    msat_ctrl #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_frame_byte      (i_frame_byte),
        .i_last_byte       (i_last_byte),
        .i_rssi            (i_rssi),
        .i_channel         (i_channel),
        .i_read_index      (i_read_index),
        .o_launch          (w_chain[0]),
        .i_exit            (w_chain[TABLE_ENTRIES]),
        .o_count           (w_count),
        .o_wr              (w_wr),
        .o_strobe          (o_strobe),
        .o_result_kind     (o_result_kind),
        .o_outcome         (o_outcome),
        .o_entry_valid     (o_entry_valid),
        .o_entry_addr      (o_entry_addr),
        .o_entry_addr_long (o_entry_addr_long),
        .o_entry_rssi      (o_entry_rssi),
        .o_entry_channel   (o_entry_channel),
        .o_device_count    (o_device_count)
    );

    // row of table cells, query word moves one cell per cycle
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        msat_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .i_count (w_count),
            .i_wr    (w_wr),
            .o_tok   (w_chain[g+1])
        );
    end

endmodule

>>> sv/msat_cell.sv
// ----------------------------------------------------------------------------
// msat_cell
// One table entry plus one stage of the query chain
// ----------------------------------------------------------------------------
module msat_cell import msat_pkg::*; #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_token            i_tok,
    input  logic [CNT_W-1:0]  i_count,
    input  t_wr               i_wr,
    output t_token            o_tok
);

    logic [63:0]       r_addr;
    logic              r_long;
    logic signed [7:0] r_rssi;
    logic [4:0]        r_ch;
    t_token            r_tok;
    t_token            n_tok;

    logic in_use;
    logic key_hit;
    logic hit;
    logic raise;
    logic wr_here;

    // match against the query word
    always_comb begin
        in_use  = CNT_W'(CELL_IDX) < i_count;
        key_hit = (r_long == i_tok.is_long) && (r_addr == i_tok.addr);
        hit     = i_tok.vld && !i_tok.found && in_use &&
                  (i_tok.is_read ? (i_tok.idx == IDX_W'(CELL_IDX)) : key_hit);
        raise   = hit && !i_tok.is_read && (i_tok.new_rssi > r_rssi);
        wr_here = i_wr.en && (i_wr.idx == IDX_W'(CELL_IDX));
        n_tok   = i_tok;
        if (hit) begin
            n_tok.found   = 1'b1;
            n_tok.addr    = r_addr;
            n_tok.is_long = r_long;
            n_tok.rssi    = raise ? i_tok.new_rssi : r_rssi;
            n_tok.ch      = r_ch;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_addr <= i_wr.addr;
            r_long <= i_wr.is_long;
            r_rssi <= i_wr.rssi;
            r_ch   <= i_wr.ch;
        end else if (raise) begin
            r_rssi <= i_tok.new_rssi;
        end
    end

    // chain stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> sv/msat_ctrl.sv
// ----------------------------------------------------------------------------
// msat_ctrl
// Frame header parser, query launch and result formatting
// ----------------------------------------------------------------------------
module msat_ctrl import msat_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_last_byte,
    input  logic signed [7:0] i_rssi,
    input  logic [4:0]        i_channel,
    input  logic [5:0]        i_read_index,
    output t_token            o_launch,
    input  t_token            i_exit,
    output logic [CNT_W-1:0]  o_count,
    output t_wr               o_wr,
    output logic              o_strobe,
    output logic              o_result_kind,
    output logic [1:0]        o_outcome,
    output logic              o_entry_valid,
    output logic [63:0]       o_entry_addr,
    output logic              o_entry_addr_long,
    output logic signed [7:0] o_entry_rssi,
    output logic [4:0]        o_entry_channel,
    output logic [6:0]        o_device_count
);

    // control state
    logic              r_busy;
    logic [6:0]        r_pos, n_pos;
    logic [15:0]       r_fcf, n_fcf;
    logic [63:0]       r_shift, n_shift;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [4:0]        r_chan;

    // result register
    logic              r_strobe;
    logic              r_kind;
    t_outcome          r_outcome;
    logic              r_evalid;
    logic [63:0]       r_eaddr;
    logic              r_elong;
    logic signed [7:0] r_erssi;
    logic [4:0]        r_ech;
    logic [CNT_W-1:0]  r_dcount;

    logic       accept;
    t_cmd       cmd;
    logic       pos_ok;
    logic [6:0] len;
    logic [4:0] off;
    logic [3:0] sl;
    logic [7:0] src_end;
    logic       in_win;
    logic [2:0] lane;
    logic       qual;
    logic       frame_end;
    logic       launch;
    logic       room;

    // header tracking for the incoming byte
    always_comb begin
        accept    = start && !r_busy;
        cmd       = t_cmd'(i_command);
        pos_ok    = r_pos < 7'(MAX_FRAME_BYTES);
        n_fcf     = r_fcf;
        n_shift   = r_shift;
        off       = src_offset(r_fcf);
        sl        = src_len(r_fcf);
        src_end   = 8'(off) + 8'(sl);
        in_win    = (sl != 4'd0) && ({1'b0, r_pos} >= 8'(off)) && ({1'b0, r_pos} < src_end);
        lane      = 3'(r_pos - 7'(off));
        if (pos_ok) begin
            if (r_pos == 7'd0) begin
                n_fcf[7:0] = i_frame_byte;
            end else if (r_pos == 7'd1) begin
                n_fcf[15:8] = i_frame_byte;
            end else if (in_win) begin
                n_shift[{lane, 3'b000} +: 8] = i_frame_byte;
            end
        end
        len       = pos_ok ? r_pos + 7'd1 : r_pos;
        frame_end = accept && (cmd == CMD_FRAME) && i_last_byte;
        // qualification on the updated header
        qual      = (len >= 7'd3) && (src_len(n_fcf) != 4'd0) &&
                    ((8'(src_offset(n_fcf)) + 8'(src_len(n_fcf))) <= {1'b0, len});
        launch    = (frame_end && qual) || (accept && (cmd == CMD_READ));
        room      = r_count < CNT_W'(TABLE_ENTRIES);
    end

    // query word into the first cell
    always_comb begin
        o_launch          = '0;
        o_launch.vld      = launch;
        o_launch.is_read  = (cmd == CMD_READ);
        o_launch.idx      = IDX_W'(i_read_index);
        o_launch.addr     = n_shift;
        o_launch.is_long  = (src_len(n_fcf) == 4'd8);
        o_launch.new_rssi = i_rssi;
    end

    // new entry on a miss with room left
    always_comb begin
        o_wr         = '0;
        o_wr.en      = i_exit.vld && !i_exit.is_read && !i_exit.found && room;
        o_wr.idx     = IDX_W'(r_count);
        o_wr.addr    = i_exit.addr;
        o_wr.is_long = i_exit.is_long;
        o_wr.rssi    = i_exit.new_rssi;
        o_wr.ch      = r_chan;
    end

    // next frame position and entry count
    always_comb begin
        n_pos   = r_pos;
        n_count = r_count;
        if (accept && (cmd == CMD_FRAME)) begin
            n_pos = i_last_byte ? 7'd0 : len;
        end
        if (accept && (cmd == CMD_CLEAR)) begin
            n_count = '0;
        end else if (o_wr.en) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pos   <= '0;
            r_fcf   <= '0;
            r_shift <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            r_pos   <= n_pos;
            if (launch) begin
                r_busy <= 1'b1;
            end else if (i_exit.vld) begin
                r_busy <= 1'b0;
            end
            if (frame_end) begin
                r_fcf   <= '0;
                r_shift <= '0;
            end else if (accept && (cmd == CMD_FRAME)) begin
                r_fcf   <= n_fcf;
                r_shift <= n_shift;
            end
        end
    end

    // channel of the frame in flight
    always_ff @(posedge i_clk) begin
        if (frame_end) begin
            r_chan <= i_channel;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_exit.vld || (frame_end && !qual);
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_exit.vld) begin
            r_kind   <= i_exit.is_read;
            r_dcount <= n_count;
            if (i_exit.found) begin
                r_outcome <= i_exit.is_read ? OUT_NONE : OUT_MATCHED;
                r_evalid  <= 1'b1;
                r_eaddr   <= i_exit.addr;
                r_elong   <= i_exit.is_long;
                r_erssi   <= i_exit.rssi;
                r_ech     <= i_exit.ch;
            end else if (!i_exit.is_read && room) begin
                r_outcome <= OUT_ADDED;
                r_evalid  <= 1'b1;
                r_eaddr   <= i_exit.addr;
                r_elong   <= i_exit.is_long;
                r_erssi   <= i_exit.new_rssi;
                r_ech     <= r_chan;
            end else begin
                r_outcome <= i_exit.is_read ? OUT_NONE : OUT_FULL;
                r_evalid  <= 1'b0;
                r_eaddr   <= '0;
                r_elong   <= 1'b0;
                r_erssi   <= '0;
                r_ech     <= '0;
            end
        end else if (frame_end && !qual) begin
            r_kind    <= 1'b0;
            r_outcome <= OUT_NONE;
            r_evalid  <= 1'b0;
            r_eaddr   <= '0;
            r_elong   <= 1'b0;
            r_erssi   <= '0;
            r_ech     <= '0;
            r_dcount  <= r_count;
        end
    end

    assign busy              = r_busy;
    assign o_count           = r_count;
    assign o_strobe          = r_strobe;
    assign o_result_kind     = r_kind;
    assign o_outcome         = r_outcome;
    assign o_entry_valid     = r_evalid;
    assign o_entry_addr      = r_eaddr;
    assign o_entry_addr_long = r_elong;
    assign o_entry_rssi      = r_erssi;
    assign o_entry_channel   = r_ech;
    assign o_device_count    = 7'(r_dcount);

endmodule

>>> sv/msat_checker.sv
// ----------------------------------------------------------------------------
// msat_checker
// Port level checks on result words of the source address table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msat_checker import msat_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              busy,
    input logic              o_strobe,
    input logic              o_result_kind,
    input logic [1:0]        o_outcome,
    input logic              o_entry_valid,
    input logic [63:0]       o_entry_addr,
    input logic [6:0]        o_device_count
);

    // a read word never carries a frame outcome
    `ASSERT_RST(a_read_no_outcome, i_clk, i_rst_n, o_strobe && o_result_kind |-> o_outcome == OUT_NONE, "read word with frame outcome")

    // frame word: entry shown exactly for added or matched
    `ASSERT_RST(a_frame_entry, i_clk, i_rst_n, o_strobe && !o_result_kind |-> o_entry_valid == (o_outcome == OUT_ADDED || o_outcome == OUT_MATCHED), "entry valid disagrees with outcome")

    // empty entry reads as zero
    `ASSERT_RST(a_empty_zero, i_clk, i_rst_n, o_strobe && !o_entry_valid |-> o_entry_addr == 64'd0, "invalid entry with nonzero address")

    // an added entry leaves the table non-empty
    `ASSERT_RST(a_added_count, i_clk, i_rst_n, o_strobe && !o_result_kind && o_outcome == OUT_ADDED |-> o_device_count != 7'd0, "added with empty table")

    // a finished query always delivers its word
    `ASSERT_CLK(a_busy_ends, i_clk, $fell(busy) && $past(i_rst_n) && i_rst_n |-> o_strobe, "query ended without a result word")

endmodule

bind mac_source_address_table msat_checker u_msat_checker (.*);

>>> bench/mac_source_address_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_source_address_table_tb
// Self-checking bench for the 802.15.4 source address table: a short table
// of directed words, then random frames, reads and clears, with a table-fill
// pass that drives the device table to full. Every strobed result is checked against
// its directed row's result or a local model of the frame parser and the device table.
// ----------------------------------------------------------------------------
module mac_source_address_table_tb;
    import msat_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int MAX_BYTES     = MAX_FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int FILL_FRAMES   = TABLE_ENTRIES + 2;

    // one input word
    typedef struct {
        t_cmd              cmd;
        logic [7:0]        fbyte;
        logic              last;
        logic signed [7:0] rssi;
        logic [4:0]        chan;
        logic [5:0]        ridx;
    } t_word;

    // one result word
    typedef struct {
        logic              kind;
        t_outcome          outcome;
        logic              valid;
        logic [63:0]       addr;
        logic              is_long;
        logic signed [7:0] rssi;
        logic [4:0]        chan;
        logic [6:0]        count;
    } t_dev_result;

    // directed table row
    typedef struct {
        t_word       w;
        bit          typed;
        t_dev_result r;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [7:0]        i_frame_byte;
    logic              i_last_byte;
    logic signed [7:0] i_rssi;
    logic [4:0]        i_channel;
    logic [5:0]        i_read_index;
    logic              o_strobe;
    logic              o_result_kind;
    logic [1:0]        o_outcome;
    logic              o_entry_valid;
    logic [63:0]       o_entry_addr;
    logic              o_entry_addr_long;
    logic signed [7:0] o_entry_rssi;
    logic [4:0]        o_entry_channel;
    logic [6:0]        o_device_count;

    // model state of the table and the frame parser
    logic [63:0]       tbl_addr [TABLE_ENTRIES];
    logic              tbl_long [TABLE_ENTRIES];
    logic signed [7:0] tbl_rssi [TABLE_ENTRIES];
    logic [4:0]        tbl_chan [TABLE_ENTRIES];
    int                dev_count;
    int                frame_pos;
    logic [15:0]       cur_fcf;
    logic [63:0]       addr_acc;

    t_dev_result pending_results [$];
    t_dir_row    dir_tab [$];
    logic [15:0] short_pool [6];
    logic [63:0] long_pool [6];
    int          mismatch_count;
    int          words_sent;
    int          burst_left;
    int          cycle_count;

    mac_source_address_table DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_frame_byte      (i_frame_byte),
        .i_last_byte       (i_last_byte),
        .i_rssi            (i_rssi),
        .i_channel         (i_channel),
        .i_read_index      (i_read_index),
        .o_strobe          (o_strobe),
        .o_result_kind     (o_result_kind),
        .o_outcome         (o_outcome),
        .o_entry_valid     (o_entry_valid),
        .o_entry_addr      (o_entry_addr),
        .o_entry_addr_long (o_entry_addr_long),
        .o_entry_rssi      (o_entry_rssi),
        .o_entry_channel   (o_entry_channel),
        .o_device_count    (o_device_count)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_word word_of(t_cmd c, logic [7:0] b, logic l,
                                      logic signed [7:0] r, logic [4:0] ch,
                                      logic [5:0] ix);
        t_word w;
        w.cmd   = c;
        w.fbyte = b;
        w.last  = l;
        w.rssi  = r;
        w.chan  = ch;
        w.ridx  = ix;
        return w;
    endfunction

    // result with empty entry fields
    function automatic t_dev_result result_of(logic k, t_outcome o, logic [6:0] n);
        t_dev_result r;
        r.kind    = k;
        r.outcome = o;
        r.valid   = 1'b0;
        r.addr    = '0;
        r.is_long = 1'b0;
        r.rssi    = '0;
        r.chan    = '0;
        r.count   = n;
        return r;
    endfunction

    function automatic t_dev_result with_entry(t_dev_result r, int i);
        r.valid   = 1'b1;
        r.addr    = tbl_addr[i];
        r.is_long = tbl_long[i];
        r.rssi    = tbl_rssi[i];
        r.chan    = tbl_chan[i];
        return r;
    endfunction

    // bytes in front of the source address: fcf, seq, dest pan/addr, src pan
    function automatic int header_bytes(logic [15:0] fcf);
        int n;
        n = 3;
        case (t_amode'(fcf[11:10]))
            AMODE_RSVD:  n = n + 2;
            AMODE_SHORT: n = n + 4;
            AMODE_LONG:  n = n + 10;
            default:     n = n;
        endcase
        if (fcf[FCF_PAN_COMP_BIT] == 1'b0) n = n + 2;
        return n;
    endfunction

    function automatic int source_bytes(logic [15:0] fcf);
        if (t_amode'(fcf[15:14]) == AMODE_LONG) return 8;
        if (t_amode'(fcf[15:14]) == AMODE_SHORT) return 2;
        return 0;
    endfunction

    // predicted effect of one accepted word on the table
    task automatic predict_table_result(input t_word w, output bit has_res,
                                        output t_dev_result res);
        int   hdr;
        int   slen;
        int   i;
        int   hit;
        logic is_long;
        begin
            res     = result_of(1'b0, OUT_NONE, 7'd0);
            has_res = 1'b0;
            hdr     = header_bytes(cur_fcf);
            slen    = source_bytes(cur_fcf);
            case (w.cmd)
                CMD_CLEAR: dev_count = 0;
                CMD_READ: begin
                    has_res  = 1'b1;
                    res.kind = 1'b1;
                    if (int'(w.ridx) < dev_count) res = with_entry(res, int'(w.ridx));
                    res.count = 7'(dev_count);
                end
                CMD_FRAME: begin
                    // collect the byte while inside the frame limit
                    if (frame_pos < MAX_BYTES) begin
                        if (frame_pos == 0) begin
                            cur_fcf[7:0] = w.fbyte;
                        end else if (frame_pos == 1) begin
                            cur_fcf[15:8] = w.fbyte;
                        end else if (slen != 0 && frame_pos >= hdr
                                     && frame_pos < hdr + slen) begin
                            addr_acc[8*(frame_pos-hdr) +: 8] = w.fbyte;
                        end
                        frame_pos++;
                    end
                    // frame end: look up or insert the source address
                    if (w.last) begin
                        has_res = 1'b1;
                        hdr     = header_bytes(cur_fcf);
                        slen    = source_bytes(cur_fcf);
                        if (frame_pos >= 3 && slen != 0 && hdr + slen <= frame_pos) begin
                            is_long = (slen == 8);
                            hit     = -1;
                            for (i = 0; i < dev_count; i++) begin
                                if (hit < 0 && tbl_long[i] == is_long && tbl_addr[i] == addr_acc)
                                    hit = i;
                            end
                            if (hit >= 0) begin
                                if (w.rssi > tbl_rssi[hit]) tbl_rssi[hit] = w.rssi;
                                res.outcome = OUT_MATCHED;
                                res = with_entry(res, hit);
                            end else if (dev_count < TABLE_ENTRIES) begin
                                tbl_addr[dev_count] = addr_acc;
                                tbl_long[dev_count] = is_long;
                                tbl_rssi[dev_count] = w.rssi;
                                tbl_chan[dev_count] = w.chan;
                                res.outcome = OUT_ADDED;
                                res = with_entry(res, dev_count);
                                dev_count++;
                            end else begin
                                res.outcome = OUT_FULL;
                            end
                        end
                        res.count = 7'(dev_count);
                        frame_pos = 0;
                        cur_fcf   = '0;
                        addr_acc  = '0;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input t_dev_result got, input t_dev_result want);
        if (got.kind !== want.kind) report_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
        if (got.outcome !== want.outcome)
            report_mismatch("outcome", 64'(got.outcome), 64'(want.outcome));
        if (got.valid !== want.valid)
            report_mismatch("entry_valid", 64'(got.valid), 64'(want.valid));
        if (got.addr !== want.addr) report_mismatch("entry_addr", got.addr, want.addr);
        if (got.is_long !== want.is_long)
            report_mismatch("entry_addr_long", 64'(got.is_long), 64'(want.is_long));
        if (got.rssi !== want.rssi)
            report_mismatch("entry_rssi", 64'(got.rssi), 64'(want.rssi));
        if (got.chan !== want.chan)
            report_mismatch("entry_channel", 64'(got.chan), 64'(want.chan));
        if (got.count !== want.count)
            report_mismatch("device_count", 64'(got.count), 64'(want.count));
    endtask

    // result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        t_dev_result got;
        if (i_rst_n && o_strobe !== 1'b0) begin
            got.kind    = o_result_kind;
            got.outcome = t_outcome'(o_outcome);
            got.valid   = o_entry_valid;
            got.addr    = o_entry_addr;
            got.is_long = o_entry_addr_long;
            got.rssi    = o_entry_rssi;
            got.chan    = o_entry_channel;
            got.count   = o_device_count;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, kind", 64'(got.kind), 64'd0);
            else
                check_result(got, pending_results.pop_front());
        end
    end

    // drive one word at the falling edge, wait for it to be taken
    task automatic send_word(input t_word w, input bit typed, input t_dev_result typed_res);
        int          gap;
        bit          has_res;
        t_dev_result res;
        begin
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            burst_left--;
            @(negedge i_clk);
            if (gap != 0) begin
                start = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_command    = w.cmd;
            i_frame_byte = w.fbyte;
            i_last_byte  = w.last;
            i_rssi       = w.rssi;
            i_channel    = w.chan;
            i_read_index = w.ridx;
            start        = 1'b1;
            do @(posedge i_clk); while (busy);
            predict_table_result(w, has_res, res);
            if (has_res) pending_results.push_back(typed ? typed_res : res);
            if (w.cmd != CMD_NONE) words_sent++;
        end
    endtask

    task automatic hold_idle();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // a read, clear or ignored command with random content
    task automatic send_side_command();
        int    pick;
        t_cmd  c;
        t_word w;
        begin
            pick = $urandom_range(0, 5);
            c = (pick < 4) ? CMD_READ : (pick == 4) ? CMD_CLEAR : CMD_NONE;
            w = word_of(c, 8'($urandom), 1'($urandom), 8'($urandom),
                        5'($urandom_range(11, 26)), 6'($urandom));
            // about half the reads go near the filled part of the table
            if (c == CMD_READ && $urandom_range(0, 1) == 0)
                w.ridx = 6'($urandom_range(0, (dev_count < 63) ? dev_count : 63));
            send_word(w, 1'b0, result_of(1'b0, OUT_NONE, 7'd0));
        end
    endtask

    function automatic logic [63:0] pick_address(bit is_long);
        int k;
        k = $urandom_range(0, 5);
        if ($urandom_range(0, 3) != 0) return is_long ? long_pool[k] : 64'(short_pool[k]);
        return is_long ? {32'($urandom), 32'($urandom)} : 64'(16'($urandom));
    endfunction

    // well-formed frame with random fields, sometimes cut short
    task automatic send_random_frame(input int force_len);
        logic [15:0] fcf;
        logic [63:0] src;
        logic [7:0]  fb [$];
        int          hdr;
        int          slen;
        int          n;
        int          i;
        begin
            fcf = 16'($urandom);
            fcf[15:14] = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 1))
                                                     : 2'($urandom_range(2, 3));
            hdr  = header_bytes(fcf);
            slen = source_bytes(fcf);
            src  = pick_address(slen == 8);
            fb.push_back(fcf[7:0]);
            fb.push_back(fcf[15:8]);
            while (fb.size() < hdr) fb.push_back(8'($urandom));
            for (i = 0; i < slen; i++) fb.push_back(src[8*i +: 8]);
            n = $urandom_range(0, 4);
            repeat (n) fb.push_back(8'($urandom));
            if (force_len > 0) begin
                while (fb.size() < force_len) fb.push_back(8'($urandom));
            end else if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, fb.size() - 1);
                while (fb.size() > n) void'(fb.pop_back());
            end
            for (i = 0; i < fb.size(); i++) begin
                if ($urandom_range(0, 24) == 0) send_side_command();
                send_word(word_of(CMD_FRAME, fb[i], i == fb.size() - 1, 8'($urandom),
                                  5'($urandom_range(11, 26)), 6'($urandom)),
                          1'b0, result_of(1'b0, OUT_NONE, 7'd0));
            end
        end
    endtask

    // smallest frame with a short source address and no destination
    task automatic send_short_frame(input logic [7:0] a0, input logic [7:0] a1);
        logic [7:0] fb [5];
        int         i;
        begin
            fb[0] = {1'($urandom), 1'b1, 6'($urandom)};
            fb[1] = {AMODE_SHORT, 2'($urandom), AMODE_NONE, 2'($urandom)};
            fb[2] = 8'($urandom);
            fb[3] = a0;
            fb[4] = a1;
            for (i = 0; i < 5; i++)
                send_word(word_of(CMD_FRAME, fb[i], i == 4, 8'($urandom),
                                  5'($urandom_range(11, 26)), 6'($urandom)),
                          1'b0, result_of(1'b0, OUT_NONE, 7'd0));
        end
    endtask

    task automatic send_random_mix(input int n_words);
        int stop_at;
        int pick;
        begin
            stop_at = words_sent + n_words;
            while (words_sent < stop_at) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) send_random_frame(0);
                else send_side_command();
            end
        end
    endtask

    initial begin
        logic [7:0] fill_hi [FILL_FRAMES];
        int         k;
        // quiet inputs from time zero
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = CMD_NONE;
        i_frame_byte   = '0;
        i_last_byte    = 1'b0;
        i_rssi         = '0;
        i_channel      = 5'd11;
        i_read_index   = '0;
        mismatch_count = 0;
        words_sent     = 0;
        burst_left     = 0;
        cycle_count    = 0;
        dev_count      = 0;
        frame_pos      = 0;
        cur_fcf        = '0;
        addr_acc       = '0;

        // address pools with the extremes, so repeats hit the table
        short_pool[0] = 16'h0000;
        short_pool[1] = 16'hFFFF;
        long_pool[0]  = 64'h0;
        long_pool[1]  = '1;
        for (k = 2; k < 6; k++) begin
            short_pool[k] = 16'($urandom);
            long_pool[k]  = {32'($urandom), 32'($urandom)};
        end

        // directed words: reads of an empty table, ignored command,
        // short frame, short source address, truncated address, clear
        dir_tab.push_back('{word_of(CMD_READ, 8'h00, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b1, result_of(1'b1, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_READ, 8'hFF, 1'b1, -8'sd1, 5'd26, 6'd63),
                            1'b1, result_of(1'b1, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_NONE, 8'hFF, 1'b1, 8'sd127, 5'd26, 6'd63),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'hFF, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'hFF, 1'b1, 8'sd0, 5'd11, 6'd0),
                            1'b1, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h41, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h88, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h01, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'hCD, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'hAB, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h34, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h12, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h78, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h56, 1'b1, -8'sd128, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_READ, 8'h00, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h41, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h88, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h02, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'hCD, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'hAB, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h34, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h12, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_FRAME, 8'h78, 1'b1, 8'sd127, 5'd26, 6'd0),
                            1'b1, result_of(1'b0, OUT_NONE, 7'd1)});
        dir_tab.push_back('{word_of(CMD_CLEAR, 8'h00, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b0, result_of(1'b0, OUT_NONE, 7'd0)});
        dir_tab.push_back('{word_of(CMD_READ, 8'h00, 1'b0, 8'sd0, 5'd11, 6'd0),
                            1'b1, result_of(1'b1, OUT_NONE, 7'd0)});

        // reset
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (dir_tab[j]) send_word(dir_tab[j].w, dir_tab[j].typed, dir_tab[j].r);

        // random frames, reads and clears
        send_random_mix(30);

        // let everything drain before the table fill
        hold_idle();
        wait_results_drained();

        // fill the table with distinct short addresses, then overflow it
        send_word(word_of(CMD_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 5'd11,
                          6'($urandom)), 1'b0, result_of(1'b0, OUT_NONE, 7'd0));
        for (k = 0; k < FILL_FRAMES; k++) begin
            fill_hi[k] = 8'($urandom);
            send_short_frame(8'(k), fill_hi[k]);
        end
        send_word(word_of(CMD_READ, 8'h00, 1'b0, 8'sd0, 5'd11, 6'd63),
                  1'b0, result_of(1'b0, OUT_NONE, 7'd0));
        send_short_frame(8'd5, fill_hi[5]);
        send_short_frame(8'd200, 8'($urandom));
        send_random_mix(10);

        // fresh table, more random traffic and one frame near or past the byte limit
        send_word(word_of(CMD_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 5'd11,
                          6'($urandom)), 1'b0, result_of(1'b0, OUT_NONE, 7'd0));
        send_random_mix(10);
        send_random_frame($urandom_range(MAX_BYTES - 1, MAX_BYTES + 4));
        send_random_mix(10);

        // drain and let the last table pass finish
        hold_idle();
        wait_results_drained();
        repeat (TABLE_ENTRIES + 10) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 64'(pending_results.size()), 64'd0);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> mac_source_address_table.f
+incdir+sv
sv/msat_pkg.sv
sv/msat_cell.sv
sv/msat_ctrl.sv
sv/mac_source_address_table.sv
sv/msat_checker.sv
bench/mac_source_address_table_tb.sv
